FILE: rtl/lcpv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcpv_pkg
// Shared constants and saturation helper for the pathwise vega estimator.
// ----------------------------------------------------------------------------
package lcpv_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_PATHS = 65535;
  localparam int DivisorW  = 31;

  localparam logic [63:0] Lim48   = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] Lim32   = 64'h0000_0000_7FFF_FFFF;
  localparam logic [31:0] Ln2Q30  = 32'd744261118;

  localparam logic signed [65:0] Lim48S = 66'sh7FFF_FFFF_FFFF;

  function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
    logic signed [47:0] r;
    if (v > Lim48S) begin
      r = Lim48S[47:0];
    end else if (v < -Lim48S) begin
      r = -Lim48S[47:0];
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/lookback_call_pathwise_vega.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lookback_call_pathwise_vega
// Pathwise vega of a lookback floating-strike call, Q16.16 fixed point.
// A path-opening sample goes straight to the final update; any other sample
//   runs two divider passes, the leading-zero normalization and squaring
//   loop of the log, and several passes through the shared multiplier.
// A last sample of the last path adds a divider pass and a multiply for the mean.
// One sample at a time; reset clears all path state and the running sum.
// ----------------------------------------------------------------------------
module lookback_call_pathwise_vega
  import lcpv_pkg::*;
#(
  parameter int FracBits = FRAC_BITS,
  parameter int MaxPaths = MAX_PATHS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [30:0]        price_i,
  input  logic               first_of_path_i,
  input  logic               last_of_path_i,
  input  logic               last_path_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] vega_o,
  output logic [15:0]        paths_done_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int DivW = (47 + FracBits > 63) ? 47 + FracBits : 63;
  localparam int Sh   = 32 - FracBits;
  localparam int LgW  = FracBits + 7;
  localparam int ItW  = $clog2(FracBits + 1);

  localparam logic [1:0] CfgRate = 2'd0;
  localparam logic [1:0] CfgVol  = 2'd1;
  localparam logic [1:0] CfgDt   = 2'd2;
  localparam logic [1:0] CfgDisc = 2'd3;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_RATIO  = 12'b0000_0000_0010,
    S_NORM   = 12'b0000_0000_0100,
    S_SQ     = 12'b0000_0000_1000,
    S_LNSC   = 12'b0000_0001_0000,
    S_SIG2   = 12'b0000_0010_0000,
    S_MULHI  = 12'b0000_0100_0000,
    S_MULLO  = 12'b0000_1000_0000,
    S_MULFIN = 12'b0001_0000_0000,
    S_QDIV   = 12'b0010_0000_0000,
    S_FIN    = 12'b0100_0000_0000,
    S_MEAN   = 12'b1000_0000_0000
  } state_e;

  typedef enum logic [2:0] {
    M_DRIFT, M_SD, M_STERM, M_GROW, M_VEGA
  } mstep_e;

  state_e state_q, state_d;
  mstep_e mstep_q, mstep_d;

  logic signed [31:0] rate_q;
  logic [30:0]        vol_q, dt_q;
  logic [16:0]        disc_q;
  logic [30:0]        sig;

  logic               ph_q, ph_d;
  logic [30:0]        price_q, price_d;
  logic               last_q, last_d, lastrun_q, lastrun_d, start_q, start_d;
  logic [30:0]        prev_q, prev_d, min_q, min_d;
  logic signed [47:0] sensp_q, sensp_d, sam_q, sam_d, sens_q, sens_d;
  logic signed [63:0] sum_q, sum_d;
  logic [15:0]        cnt_q, cnt_d;
  logic [31:0]        ratio_q, ratio_d, x_q, x_d;
  logic [4:0]         n_q, n_d;
  logic [FracBits-1:0] frac_q, frac_d;
  logic [ItW-1:0]     it_q, it_d;
  logic signed [47:0] l_q, l_d, drift_q, drift_d, sd_q, sd_d, sterm_q, sterm_d;
  logic               qneg_q, qneg_d, sumneg_q, sumneg_d;
  logic signed [63:0] opa_q, opa_d;
  logic [31:0]        opb_q, opb_d;
  logic [63:0]        hi_q, hi_d;
  logic               out_valid_q, out_valid_d;
  logic [31:0]        vega_q, vega_d;
  logic [15:0]        paths_q, paths_d;

  logic               div_start, div_busy;
  logic [DivW-1:0]    div_dvd, div_quot;
  logic [30:0]        div_dvs;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;

  logic [63:0]        amag, lim, r, mres;
  logic signed [LgW-1:0] lg;
  logic [LgW-1:0]     lgmag;
  logic [31:0]        sqp;
  logic signed [47:0] diff, qv, term, sam_new;
  logic [47:0]        dmag, qmag;
  logic signed [64:0] acc;
  logic signed [63:0] sum_new;
  logic [15:0]        cnt_new;
  logic [63:0]        smag, lmag;
  logic               out_free;

  assign sig   = (vol_q == '0) ? 31'd1 : vol_q;
  assign amag  = opa_q[63] ? 64'(-opa_q) : 64'(opa_q);
  assign lg    = ((LgW'(n_q) - LgW'(FracBits)) << FracBits) | LgW'(frac_q);
  assign lgmag = lg[LgW-1] ? LgW'(-lg) : LgW'(lg);
  assign sqp   = mul_p[61:30];
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    lim = (mstep_q == M_VEGA) ? Lim32 : Lim48;
    if (hi_q > (lim >> Sh)) begin
      r = lim;
    end else begin
      r = (hi_q << Sh) + (mul_p >> FracBits);
      if (r > lim) begin
        r = lim;
      end
    end
    mres = opa_q[63] ? -r : r;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SQ: begin
        mul_a = {1'b0, x_q[31:1]};
        mul_b = {1'b0, x_q[31:1]};
      end
      S_LNSC: begin
        mul_a = 32'(lgmag);
        mul_b = Ln2Q30;
      end
      S_SIG2: begin
        mul_a = {1'b0, sig};
        mul_b = {1'b0, sig};
      end
      S_MULHI: begin
        mul_a = amag[63:32];
        mul_b = opb_q;
      end
      S_MULLO, S_MULFIN: begin
        mul_a = amag[31:0];
        mul_b = opb_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;  mstep_d = mstep_q;  ph_d = ph_q;
    price_d = price_q;  last_d = last_q;    lastrun_d = lastrun_q;
    start_d = start_q;  prev_d = prev_q;    min_d = min_q;
    sensp_d = sensp_q;  sam_d = sam_q;      sens_d = sens_q;
    sum_d = sum_q;      cnt_d = cnt_q;      ratio_d = ratio_q;
    x_d = x_q;          n_d = n_q;          frac_d = frac_q;
    it_d = it_q;        l_d = l_q;          drift_d = drift_q;
    sd_d = sd_q;        sterm_d = sterm_q;  qneg_d = qneg_q;
    sumneg_d = sumneg_q; opa_d = opa_q;     opb_d = opb_q;
    hi_d = hi_q;        vega_d = vega_q;    paths_d = paths_q;
    out_valid_d = out_valid_q && out_stall_i;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;

    diff    = sat48(66'(l_q) - 66'(drift_q));
    dmag    = diff[47] ? 48'(-diff) : 48'(diff);
    qmag    = (div_quot > DivW'(Lim48)) ? Lim48[47:0] : div_quot[47:0];
    qv      = qneg_q ? -$signed(qmag) : $signed(qmag);
    term    = sat48(66'(qv) - 66'(sd_q));
    lmag    = mul_p >> 30;

    if (start_q) begin
      sam_new = '0;
    end else if (price_q < min_q) begin
      sam_new = sens_q;
    end else begin
      sam_new = sam_q;
    end
    acc = 65'(sum_q) + 65'(sens_q) - 65'(sam_new);
    if (acc > 65'sh7FFF_FFFF_FFFF_FFFF) begin
      sum_new = 64'sh7FFF_FFFF_FFFF_FFFF;
    end else if (acc < -65'sh7FFF_FFFF_FFFF_FFFF) begin
      sum_new = -64'sh7FFF_FFFF_FFFF_FFFF;
    end else begin
      sum_new = acc[63:0];
    end
    cnt_new = cnt_q;
    if (last_q && (cnt_q < 16'(MaxPaths))) begin
      cnt_new = cnt_q + 16'd1;
    end else begin
      sum_new = sum_q;
    end
    if (!last_q) begin
      sum_new = sum_q;
    end
    smag = sum_new[63] ? 64'(-sum_new) : 64'(sum_new);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          price_d   = price_i;
          last_d    = last_of_path_i;
          lastrun_d = last_path_i;
          if (first_of_path_i || prev_q == '0) begin
            start_d = 1'b1;
            sens_d  = '0;
            state_d = S_FIN;
          end else begin
            start_d   = 1'b0;
            div_start = 1'b1;
            div_dvd   = DivW'(price_i) << FracBits;
            div_dvs   = prev_q;
            state_d   = S_RATIO;
          end
        end
      end
      S_RATIO: begin
        if (!div_busy) begin
          if (div_quot == '0) begin
            ratio_d = 32'd1;
          end else if (|(div_quot >> 32)) begin
            ratio_d = 32'hFFFF_FFFF;
          end else begin
            ratio_d = div_quot[31:0];
          end
          x_d     = ratio_d;
          n_d     = 5'd31;
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        if (x_q[31]) begin
          frac_d  = '0;
          it_d    = '0;
          ph_d    = 1'b0;
          state_d = S_SQ;
        end else begin
          x_d = x_q << 1;
          n_d = n_q - 5'd1;
        end
      end
      S_SQ: begin
        ph_d = !ph_q;
        if (ph_q) begin
          if (sqp[31]) begin
            x_d    = {sqp[31:1], 1'b0};
            frac_d = {frac_q[FracBits-2:0], 1'b1};
          end else begin
            x_d    = {sqp[30:0], 1'b0};
            frac_d = {frac_q[FracBits-2:0], 1'b0};
          end
          it_d = it_q + 1'b1;
          if (it_q == ItW'(FracBits - 1)) begin
            state_d = S_LNSC;
          end
        end
      end
      S_LNSC: begin
        ph_d = !ph_q;
        if (ph_q) begin
          l_d     = lg[LgW-1] ? -$signed(lmag[47:0]) : $signed(lmag[47:0]);
          state_d = S_SIG2;
        end
      end
      S_SIG2: begin
        ph_d = !ph_q;
        if (ph_q) begin
          opa_d   = 64'(rate_q) - (mul_p >> (FracBits + 1));
          opb_d   = {1'b0, dt_q};
          mstep_d = M_DRIFT;
          state_d = S_MULHI;
        end
      end
      S_MULHI: begin
        state_d = S_MULLO;
      end
      S_MULLO: begin
        hi_d    = mul_p;
        state_d = S_MULFIN;
      end
      S_MULFIN: begin
        case (mstep_q)
          M_DRIFT: begin
            drift_d = mres[47:0];
            opa_d   = 64'(sig);
            opb_d   = {1'b0, dt_q};
            mstep_d = M_SD;
            state_d = S_MULHI;
          end
          M_SD: begin
            sd_d      = mres[47:0];
            qneg_d    = diff[47];
            div_start = 1'b1;
            div_dvd   = DivW'(dmag) << FracBits;
            div_dvs   = sig;
            state_d   = S_QDIV;
          end
          M_STERM: begin
            sterm_d = mres[47:0];
            opa_d   = 64'(sensp_q);
            opb_d   = ratio_q;
            mstep_d = M_GROW;
            state_d = S_MULHI;
          end
          M_GROW: begin
            sens_d  = sat48(66'($signed(mres[47:0])) + 66'(sterm_q));
            state_d = S_FIN;
          end
          M_VEGA: begin
            if (out_free) begin
              out_valid_d = 1'b1;
              vega_d      = mres[31:0];
              paths_d     = cnt_q;
              sum_d       = '0;
              cnt_d       = '0;
              state_d     = S_IDLE;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_QDIV: begin
        if (!div_busy) begin
          opa_d   = 64'(term);
          opb_d   = {1'b0, price_q};
          mstep_d = M_STERM;
          state_d = S_MULHI;
        end
      end
      S_FIN: begin
        prev_d  = price_q;
        sensp_d = sens_q;
        sam_d   = sam_new;
        if (start_q || price_q < min_q) begin
          min_d = price_q;
        end
        sum_d = sum_new;
        cnt_d = cnt_new;
        if (last_q && lastrun_q) begin
          sumneg_d  = sum_new[63];
          div_start = 1'b1;
          div_dvd   = DivW'(smag[62:0]);
          div_dvs   = 31'(cnt_new);
          state_d   = S_MEAN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_MEAN: begin
        if (!div_busy) begin
          opa_d   = sumneg_q ? -$signed(64'(div_quot[62:0]))
                             : $signed(64'(div_quot[62:0]));
          opb_d   = 32'(disc_q);
          mstep_d = M_VEGA;
          state_d = S_MULHI;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mstep_q     <= M_DRIFT;
      ph_q        <= 1'b0;
      out_valid_q <= 1'b0;
      rate_q      <= '0;
      vol_q       <= 31'd65536;
      dt_q        <= 31'd655;
      disc_q      <= 17'd65536;
      prev_q      <= '0;
      sensp_q     <= '0;
      min_q       <= '0;
      sam_q       <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      mstep_q     <= mstep_d;
      ph_q        <= ph_d;
      out_valid_q <= out_valid_d;
      prev_q      <= prev_d;
      sensp_q     <= sensp_d;
      min_q       <= min_d;
      sam_q       <= sam_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgRate: rate_q <= cfg_data_i;
          CfgVol:  vol_q  <= cfg_data_i[30:0];
          CfgDt:   dt_q   <= cfg_data_i[30:0];
          CfgDisc: disc_q <= cfg_data_i[16:0];
          default: rate_q <= rate_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    price_q   <= price_d;
    last_q    <= last_d;
    lastrun_q <= lastrun_d;
    start_q   <= start_d;
    sens_q    <= sens_d;
    ratio_q   <= ratio_d;
    x_q       <= x_d;
    n_q       <= n_d;
    frac_q    <= frac_d;
    it_q      <= it_d;
    l_q       <= l_d;
    drift_q   <= drift_d;
    sd_q      <= sd_d;
    sterm_q   <= sterm_d;
    qneg_q    <= qneg_d;
    sumneg_q  <= sumneg_d;
    opa_q     <= opa_d;
    opb_q     <= opb_d;
    hi_q      <= hi_d;
    vega_q    <= vega_d;
    paths_q   <= paths_d;
  end

  lcpv_div #(
    .DivW(DivW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  lcpv_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_p)
  );

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign vega_o       = vega_q;
  assign paths_done_o = paths_q;
  assign cfg_ready_o  = 1'b1;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_MULFIN && mstep_q == M_VEGA))
    else $error("result raised outside final step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 16'(MaxPaths))
    else $error("path count past limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SQ) |-> x_q[31])
    else $error("log mantissa not normalized");

endmodule

FILE: rtl/lcpv_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcpv_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module lcpv_div
  import lcpv_pkg::*;
#(
  parameter int DivW = 63
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DivW-1:0]     dividend_i,
  input  logic [DivisorW-1:0] divisor_i,
  output logic                busy_o,
  output logic [DivW-1:0]     quot_o
);

  localparam int CW = $clog2(DivW + 1);

  logic [CW-1:0]       cnt_q, cnt_d;
  logic [DivW-1:0]     quot_q, quot_d;
  logic [DivisorW-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [DivisorW:0]   trial;

  always_comb begin
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, quot_q[DivW-1]};
    if (start_i) begin
      cnt_d  = CW'(DivW);
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = DivisorW'(trial - {1'b0, dvs_q});
        quot_d = {quot_q[DivW-2:0], 1'b1};
      end else begin
        rem_d  = trial[DivisorW-1:0];
        quot_d = {quot_q[DivW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quot_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_o)
    else $error("divider did not start");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && !start_i) |=> (rem_q < dvs_q))
    else $error("partial remainder not below divisor");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CW'(1) && !start_i) |=> !busy_o)
    else $error("divider overran");

endmodule

FILE: rtl/lcpv_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcpv_mul
// Shared 32x32 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module lcpv_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] prod_o
);

  logic [63:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(a_i) * 64'(b_i);
  end

  assign prod_o = prod_q;

endmodule
